// ===== design/stc_pkg.sv =====
// Shared types, status codes and rate-table function for the timecode converter.
package stc_pkg;

    localparam logic [1:0] REQ_TO_LABEL  = 2'd0;
    localparam logic [1:0] REQ_TO_FRAMES = 2'd1;
    localparam logic [1:0] REQ_ADD       = 2'd2;
    localparam logic [1:0] REQ_SUB       = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_RANGE   = 3'd1;
    localparam logic [2:0] ST_HOURS   = 3'd2;
    localparam logic [2:0] ST_MINUTES = 3'd3;
    localparam logic [2:0] ST_SECONDS = 3'd4;
    localparam logic [2:0] ST_FRAMES  = 3'd5;
    localparam logic [2:0] ST_DROPPED = 3'd6;

    localparam logic [1:0] CFG_FPS  = 2'd0;
    localparam logic [1:0] CFG_DROP = 2'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [22:0] frame_count;
        logic [5:0]  hours_in;
        logic [6:0]  minutes_in;
        logic [6:0]  seconds_in;
        logic [6:0]  frames_in;
    } t_in;

    typedef struct packed {
        logic [22:0] total_frames;
        logic [4:0]  hours_out;
        logic [5:0]  minutes_out;
        logic [5:0]  seconds_out;
        logic [5:0]  frames_out;
        logic [2:0]  status;
    } t_out;

    // Derived rate constants; their values change only on configuration writes and reset.
    typedef struct packed {
        logic [5:0]  nom;
        logic [2:0]  d;
        logic [11:0] fpm;
        logic [15:0] fp10;
        logic [17:0] fph;
        logic [22:0] day;
    } t_rates;

    function automatic t_rates calc_rates(input logic [5:0] fps, input logic drop);
        t_rates r;
        logic [6:0] n;
        n = {1'b0, fps};
        if (fps == 6'd0) n = 7'd1;
        if (fps == 6'd23 || fps == 6'd29 || fps == 6'd59) n = n + 7'd1;
        r.nom  = n[5:0] == 6'd0 ? 6'd0 : n[5:0];
        // 60 fps maps to 6'd60 (fits); 63 stays 63
        // Drop count is n/15, taken by thresholds since n stays below 64
        if (!drop) r.d = 3'd0;
        else if (n >= 7'd60) r.d = 3'd4;
        else if (n >= 7'd45) r.d = 3'd3;
        else if (n >= 7'd30) r.d = 3'd2;
        else if (n >= 7'd15) r.d = 3'd1;
        else r.d = 3'd0;
        r.fpm  = 12'(13'd60 * 13'(n) - 13'(r.d));
        r.fp10 = 16'(17'(r.fpm) * 17'd10 + 17'(r.d));
        r.fph  = 18'(19'(r.fp10) * 19'd6);
        r.day  = 23'(24'(r.fph) * 24'd24);
        return r;
    endfunction

endpackage

// ===== design/stc_decode.sv =====
// Pipelined frame number to hh:mm:ss:ff decoder (restoring compare stages).
module stc_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  stc_pkg::t_rates      i_rates,
    input  logic [22:0]          i_n,
    input  logic [2:0]           i_status,
    output logic                 o_valid,
    output stc_pkg::t_out        o_res
);
    // Stage A: hours by 5 compare steps (h < 24), then tens of minutes, etc.
    logic        r_va, r_vb, r_vc, r_vd;
    logic [22:0] r_na, r_nb, r_nc, r_nd;
    logic [2:0]  r_sa, r_sb, r_sc, r_sd;
    logic [4:0]  r_ha, r_hb, r_hc, r_hd;
    logic [22:0] r_ra;
    logic [17:0] r_rb;
    logic [2:0]  r_tb, r_tc, r_td;
    logic [14:0] r_rc;
    logic [3:0]  r_uc, r_ud;
    logic [5:0]  r_sec;
    logic [5:0]  r_fr;

    logic [22:0] n_ra;
    logic [4:0]  n_ha;
    logic [17:0] n_rb;
    logic [2:0]  n_tb;
    logic [14:0] n_rc, n_rcd;
    logic [3:0]  n_uc;
    logic [5:0]  n_sec;
    logic [11:0] n_fr;

    always_comb begin
        n_ra = i_n;
        n_ha = '0;
        for (int b = 4; b >= 0; b--) begin
            if (n_ra >= (23'(i_rates.fph) << b)) begin
                n_ra = n_ra - (23'(i_rates.fph) << b);
                n_ha[b] = 1'b1;
            end
        end
    end

    always_comb begin
        logic [17:0] t;
        t = r_ra[17:0];
        n_tb = '0;
        for (int b = 2; b >= 0; b--) begin
            if (t >= (18'(i_rates.fp10) << b)) begin
                t = t - (18'(i_rates.fp10) << b);
                n_tb[b] = 1'b1;
            end
        end
        n_rb = t;
    end

    always_comb begin
        logic [15:0] t;
        t = r_rb[15:0];
        n_uc = '0;
        n_rc = t[14:0];
        if (t >= 16'(i_rates.d)) begin
            t = t - 16'(i_rates.d);
            for (int b = 3; b >= 0; b--) begin
                if (t >= (16'(i_rates.fpm) << b)) begin
                    t = t - (16'(i_rates.fpm) << b);
                    n_uc[b] = 1'b1;
                end
            end
            n_rc = t[14:0] + 15'(i_rates.d);
        end
        n_rcd = n_rc;
    end

    always_comb begin
        logic [11:0] t;
        t = r_rc[11:0];
        n_sec = '0;
        for (int b = 5; b >= 0; b--) begin
            if (t >= (12'(i_rates.nom) << b)) begin
                t = t - (12'(i_rates.nom) << b);
                n_sec[b] = 1'b1;
            end
        end
        n_fr = t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0; r_vb <= 1'b0; r_vc <= 1'b0; r_vd <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid; r_vb <= r_va; r_vc <= r_vb; r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_na <= i_n; r_sa <= i_status; r_ha <= n_ha; r_ra <= n_ra;
            r_nb <= r_na; r_sb <= r_sa; r_hb <= r_ha; r_tb <= n_tb; r_rb <= n_rb;
            r_nc <= r_nb; r_sc <= r_sb; r_hc <= r_hb; r_tc <= r_tb; r_uc <= n_uc;
            r_rc <= n_rcd;
            r_nd <= r_nc; r_sd <= r_sc; r_hd <= r_hc; r_td <= r_tc; r_ud <= r_uc;
            r_sec <= n_sec; r_fr <= n_fr[5:0];
        end
    end

    logic [6:0] w_min;
    assign w_min = 7'(r_td) * 7'd10 + 7'(r_ud);

    always_comb begin
        o_valid = r_vd;
        if (r_sd != stc_pkg::ST_OK) begin
            o_res = '0;
            o_res.status = r_sd;
        end else begin
            o_res.total_frames = r_nd;
            o_res.hours_out    = r_hd;
            o_res.minutes_out  = w_min[5:0];
            o_res.seconds_out  = r_sec;
            o_res.frames_out   = r_fr;
            o_res.status       = r_sd;
        end
    end
endmodule

// ===== design/smpte_timecode_converter.sv =====
// Top level: SMPTE timecode converter, request checks, encode, offset, decode pipeline.
//
// Channel | Signals                  | Direction | Accepted when
// in      | i_in_valid/o_in_stall    | in        | valid && !stall
// out     | o_out_valid/i_out_stall  | out       | valid && !stall
// cfg     | i_cfg_valid/o_cfg_ready  | in        | valid && ready
//
// One transaction per cycle while the output is not stalled; three encode/offset stages
// and four decode stages. Each decode stage runs one divider as a short restoring
// compare chain against the rate constants. The whole pipe advances together;
// i_out_stall holds every stage while a result waits, and o_in_stall follows it
// so nothing is lost. Reset clears all valid bits and loads 30 fps non-drop.
module smpte_timecode_converter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  stc_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output stc_pkg::t_out  o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [5:0]     i_cfg_data
);
    logic [5:0]      r_fps;
    logic            r_drop;
    stc_pkg::t_rates r_rates;
    logic            w_en;
    logic [5:0]      n_fps;
    logic            n_drop;

    // Split minutes into tens and units by restoring compare steps.
    function automatic logic [7:0] split_minutes(input logic [6:0] mm);
        logic [6:0] t;
        logic [3:0] q;
        t = mm;
        q = '0;
        for (int b = 3; b >= 0; b--) begin
            if (t >= (7'd10 << b)) begin
                t = t - (7'd10 << b);
                q[b] = 1'b1;
            end
        end
        return {q, t[3:0]};
    endfunction

    // Advance the pipe unless the output is stalled holding a result.
    assign w_en       = !(i_out_stall && o_out_valid);
    assign o_in_stall = !w_en;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_fps  = r_fps;
        n_drop = r_drop;
        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == stc_pkg::CFG_FPS) n_fps = i_cfg_data;
            if (i_cfg_index == stc_pkg::CFG_DROP) n_drop = i_cfg_data[0];
        end
    end

    // Load the rate table at the same edge as the registers it derives from.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fps   <= 6'd30;
            r_drop  <= 1'b0;
            r_rates <= stc_pkg::calc_rates(6'd30, 1'b0);
        end else begin
            r_fps   <= n_fps;
            r_drop  <= n_drop;
            r_rates <= stc_pkg::calc_rates(n_fps, n_drop);
        end
    end

    // Stage 1: validate the label, form partial products of the encode.
    logic        r_v1;
    logic [1:0]  r_req1;
    logic [2:0]  r_st1;
    logic [22:0] r_cnt1;
    logic [22:0] r_p1h, r_p1m;
    logic [11:0] r_p1s;
    logic [15:0] r_p1u;
    logic [2:0]  n_st1;
    logic [3:0]  n_tens, n_units;
    always_comb begin
        logic [6:0] mm;
        logic       mnz;
        mm  = i_in_data.minutes_in;
        {n_tens, n_units} = split_minutes(mm);
        mnz = n_units != 4'd0;
        if (i_in_data.req_type == stc_pkg::REQ_TO_LABEL) n_st1 = stc_pkg::ST_OK;
        else if (i_in_data.hours_in > 6'd23) n_st1 = stc_pkg::ST_HOURS;
        else if (mm > 7'd59) n_st1 = stc_pkg::ST_MINUTES;
        else if (i_in_data.seconds_in > 7'd59) n_st1 = stc_pkg::ST_SECONDS;
        else if (i_in_data.frames_in >= 7'(r_rates.nom)) n_st1 = stc_pkg::ST_FRAMES;
        else if (r_drop && i_in_data.seconds_in == 7'd0 && mnz
                 && i_in_data.frames_in < 7'(r_rates.d)) n_st1 = stc_pkg::ST_DROPPED;
        else n_st1 = stc_pkg::ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (w_en) r_v1 <= i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_req1 <= i_in_data.req_type;
            r_st1  <= n_st1;
            r_cnt1 <= i_in_data.frame_count;
            r_p1h  <= 23'(i_in_data.hours_in[4:0] * 23'(r_rates.fph));
            r_p1m  <= 23'(n_tens) * 23'(r_rates.fp10);
            r_p1u  <= 16'(n_units) * 16'(r_rates.fpm);
            r_p1s  <= 12'(i_in_data.seconds_in[5:0]) * 12'(r_rates.nom)
                      + 12'(i_in_data.frames_in);
        end
    end

    // Stage 2: sum the label and reduce the offset (count below 2^23 < 2*day
    // only when day > 2^22; otherwise eight subtract steps by day << 7 down to day).
    logic        r_v2;
    logic [1:0]  r_req2;
    logic [2:0]  r_st2;
    logic [22:0] r_t2, r_off2, r_cnt2;
    logic [22:0] n_off;
    always_comb begin
        logic [30:0] t;
        t = 31'(r_cnt1);
        for (int b = 7; b >= 0; b--) begin
            if (t >= (31'(r_rates.day) << b)) t = t - (31'(r_rates.day) << b);
        end
        n_off = t[22:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (w_en) r_v2 <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_req2 <= r_req1;
            r_st2  <= r_st1;
            r_cnt2 <= r_cnt1;
            r_t2   <= r_p1h + r_p1m + 23'(r_p1u) + 23'(r_p1s);
            r_off2 <= n_off;
        end
    end

    // Stage 3: apply the offset with day wrap; range check for frames to label.
    logic        r_v3;
    logic [2:0]  r_st3;
    logic [22:0] r_n3;
    logic [2:0]  n_st3;
    logic [22:0] n_n3;
    always_comb begin
        logic [23:0] s;
        s = '0;
        n_st3 = r_st2;
        unique case (r_req2)
            stc_pkg::REQ_TO_LABEL: begin
                n_n3 = r_cnt2;
                if (r_cnt2 >= r_rates.day) n_st3 = stc_pkg::ST_RANGE;
            end
            stc_pkg::REQ_TO_FRAMES: n_n3 = r_t2;
            stc_pkg::REQ_ADD: begin
                s = 24'(r_t2) + 24'(r_off2);
                if (s >= 24'(r_rates.day)) s = s - 24'(r_rates.day);
                n_n3 = s[22:0];
            end
            default: begin
                s = 24'(r_t2) + 24'(r_rates.day) - 24'(r_off2);
                if (s >= 24'(r_rates.day)) s = s - 24'(r_rates.day);
                n_n3 = s[22:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (w_en) r_v3 <= r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st3 <= n_st3;
            r_n3  <= (n_st3 == stc_pkg::ST_OK) ? n_n3 : 23'd0;
        end
    end

    stc_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_v3),
        .i_rates  (r_rates),
        .i_n      (r_n3),
        .i_status (r_st3),
        .o_valid  (o_out_valid),
        .o_res    (o_out_data)
    );
endmodule

// ===== dv/tb_smpte_timecode_converter.sv =====
// Testbench for the SMPTE timecode converter: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tb_smpte_timecode_converter;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LATENCY     = 7;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_stall;
    stc_pkg::t_in   i_in_data = '0;
    logic  o_out_valid;
    logic  i_out_stall = 1'b0;
    stc_pkg::t_out  o_out_data;
    logic  i_cfg_valid = 1'b0;
    logic  o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [5:0] i_cfg_data = '0;

    smpte_timecode_converter u_top (.*);

    always #4 i_clk = ~i_clk;

    // Predictor copy of the rate registers
    logic [5:0] fps_q = 6'd30;
    logic       drop_q = 1'b0;

    logic [5:0] fps_set[6] = '{6'd30, 6'd29, 6'd59, 6'd0, 6'd63, 6'd24};

    stc_pkg::t_in  pending_reqs[$];
    stc_pkg::t_out expected_labels[$];
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   mismatch_count = 0;
    int unsigned cycle_count = 0;

    // Compute the expected result of one request under the current rates.
    function automatic stc_pkg::t_out convert_timecode(stc_pkg::t_in rq);
        stc_pkg::t_out o;
        longint unsigned n, d, fpm, fp10, fph, day, t, off, rem, tm, um, hh, mm, ss, ff;
        n = fps_q;
        if (n == 0) n = 1;
        if (n == 23 || n == 29 || n == 59) n = n + 1;
        d = drop_q ? n / 15 : 0;
        fpm = 60 * n - d;
        fp10 = fpm * 10 + d;
        fph = fp10 * 6;
        day = fph * 24;
        o = '0;
        hh = rq.hours_in; mm = rq.minutes_in; ss = rq.seconds_in; ff = rq.frames_in;
        if (rq.req_type == stc_pkg::REQ_TO_LABEL) begin
            if (rq.frame_count >= day) begin
                o.status = stc_pkg::ST_RANGE;
                return o;
            end
            t = rq.frame_count;
        end else begin
            if (hh > 23) begin o.status = stc_pkg::ST_HOURS; return o; end
            if (mm > 59) begin o.status = stc_pkg::ST_MINUTES; return o; end
            if (ss > 59) begin o.status = stc_pkg::ST_SECONDS; return o; end
            if (ff >= n) begin o.status = stc_pkg::ST_FRAMES; return o; end
            if (drop_q && ss == 0 && (mm % 10) != 0 && ff < d) begin
                o.status = stc_pkg::ST_DROPPED;
                return o;
            end
            t = hh * fph + (mm / 10) * fp10 + (mm % 10) * fpm + ss * n + ff;
            off = rq.frame_count % day;
            if (rq.req_type == stc_pkg::REQ_ADD) t = (t + off) % day;
            else if (rq.req_type == stc_pkg::REQ_SUB) t = (t + day - off) % day;
        end
        // Decode the frame number back to a label
        rem = t % fph;
        tm = rem / fp10;
        rem = rem % fp10;
        um = 0;
        if (rem >= d) begin
            um = (rem - d) / fpm;
            rem = (rem - d) % fpm + d;
        end
        o.total_frames = t[22:0];
        o.hours_out    = 5'(t / fph);
        o.minutes_out  = 6'(tm * 10 + um);
        o.seconds_out  = 6'(rem / n);
        o.frames_out   = 6'(rem % n);
        o.status       = stc_pkg::ST_OK;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got, exp_v);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, exp_v,
                 cycle_count);
        mismatch_count++;
    endtask

    // Driver: hold the payload while stalled, advance on acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || !o_in_stall) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_reqs.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Predict on acceptance; the predictor state only changes while idle.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            expected_labels.push_back(convert_timecode(i_in_data));
    end

    // Monitor: random receiver stall, compare each transaction with the oldest expectation.
    always @(posedge i_clk) begin
        stc_pkg::t_out e;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_labels.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    e = expected_labels.pop_front();
                    if (o_out_data.status != e.status)
                        report_mismatch("status", o_out_data.status, e.status);
                    if (o_out_data.total_frames != e.total_frames)
                        report_mismatch("total_frames", o_out_data.total_frames,
                                        e.total_frames);
                    if (o_out_data.hours_out != e.hours_out)
                        report_mismatch("hours", o_out_data.hours_out, e.hours_out);
                    if (o_out_data.minutes_out != e.minutes_out)
                        report_mismatch("minutes", o_out_data.minutes_out, e.minutes_out);
                    if (o_out_data.seconds_out != e.seconds_out)
                        report_mismatch("seconds", o_out_data.seconds_out, e.seconds_out);
                    if (o_out_data.frames_out != e.frames_out)
                        report_mismatch("frames", o_out_data.frames_out, e.frames_out);
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Wait until every queued request is accepted and all results are back.
    task automatic drain();
        while (pending_reqs.size() > 0 || i_in_valid || expected_labels.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [1:0] idx, input logic [5:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == stc_pkg::CFG_FPS) fps_q = val;
        else drop_q = val[0];
    endtask

    function automatic stc_pkg::t_in make_label(logic [1:0] rt, int unsigned cnt, hh, mm,
                                                ss, ff);
        stc_pkg::t_in r;
        r.req_type = rt; r.frame_count = 23'(cnt);
        r.hours_in = 6'(hh); r.minutes_in = 7'(mm);
        r.seconds_in = 7'(ss); r.frames_in = 7'(ff);
        return r;
    endfunction

    // Mostly legal labels at the current rate, with some wild fields.
    function automatic stc_pkg::t_in random_request();
        stc_pkg::t_in r;
        int unsigned n;
        n = (fps_q == 0) ? 1 : fps_q;
        r = stc_pkg::t_in'(52'({$urandom, $urandom}));
        if ($urandom_range(9) < 8) begin
            r.hours_in   = 6'($urandom_range(23));
            r.minutes_in = 7'($urandom_range(59));
            r.seconds_in = ($urandom_range(3) == 0) ? 7'd0 : 7'($urandom_range(59));
            r.frames_in  = 7'($urandom_range(n > 64 ? 63 : n - 1));
            if ($urandom_range(3) != 0)
                r.frame_count = 23'($urandom_range(5183999));
        end
        return r;
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset rates, extremes of every field and each error path
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_LABEL, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_LABEL, 2591999, 0, 0, 0, 0));
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_LABEL, 2592000, 63, 127, 127, 127));
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_LABEL, 8388607, 0, 0, 0, 0));
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_FRAMES, 0, 23, 59, 59, 29));
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_FRAMES, 0, 24, 0, 0, 0));
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_FRAMES, 0, 63, 127, 127, 127));
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_FRAMES, 0, 0, 60, 0, 0));
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_FRAMES, 0, 0, 0, 60, 0));
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_FRAMES, 0, 0, 0, 0, 30));
        pending_reqs.push_back(make_label(stc_pkg::REQ_ADD, 8388607, 23, 59, 59, 29));
        pending_reqs.push_back(make_label(stc_pkg::REQ_SUB, 8388607, 0, 0, 0, 0));
        pending_reqs.push_back(make_label(stc_pkg::REQ_SUB, 1, 0, 0, 0, 0));
        drain();
        write_rate(stc_pkg::CFG_DROP, 6'd1);
        // Drop-frame: skipped labels, tenth minute, minute boundaries
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_FRAMES, 0, 0, 1, 0, 0));
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_FRAMES, 0, 0, 1, 0, 1));
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_FRAMES, 0, 0, 1, 0, 2));
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_FRAMES, 0, 0, 10, 0, 0));
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_LABEL, 1799, 0, 0, 0, 0));
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_LABEL, 1800, 0, 0, 0, 0));
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_LABEL, 17982, 0, 0, 0, 0));
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_LABEL, 2589407, 0, 0, 0, 0));
        pending_reqs.push_back(make_label(stc_pkg::REQ_TO_LABEL, 2589408, 0, 0, 0, 0));
        pending_reqs.push_back(make_label(stc_pkg::REQ_ADD, 1, 0, 0, 59, 29));
        drain();

        // Random phases across rates, drop modes and idle patterns
        for (int ph = 0; ph < 12; ph++) begin
            case (ph / 4)
                0: begin send_idle_pct = 30; recv_idle_pct = 56; end
                1: begin send_idle_pct = 56; recv_idle_pct = 30; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            write_rate(stc_pkg::CFG_FPS, (ph < 6) ? fps_set[ph] : 6'($urandom_range(63)));
            write_rate(stc_pkg::CFG_DROP, 6'(ph % 2 == 0 ? 1 : $urandom_range(1)));
            for (int k = 0; k < 120; k++)
                pending_reqs.push_back(random_request());
            drain();
        end

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
